FILE: rtl/fatlb_pkg.sv
// Shared constants and types for the fully associative translation buffer.
// No dependencies; used by the top level and the checker.
`default_nettype none

package fatlb_pkg;

   localparam int unsigned TLB_ENTRIES_DEF = 16;

   localparam int unsigned MODE_W  = 2;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned STAMP_W = 32;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

   // req tdata: virtual_address, physical_address
   localparam int unsigned REQ_TDATA_W = 2 * ADDR_W;
   // rsp tdata: translated_address
   localparam int unsigned RSP_TDATA_W = ADDR_W;

   typedef struct packed {
      logic [STAMP_W-1:0] age;
      logic [ADDR_W-1:0]  frame;
      logic [ADDR_W-1:0]  tag;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

FILE: rtl/fatlb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fatlb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/fully_assoc_tlb_fifo_unit.sv
// Fully associative TLB with oldest-stamp (FIFO) replacement, entries held in one RAM.
// Depends on fatlb_pkg and fatlb_ram.
//
// Sequence: for lookup and insert, the request passes through a scan of every entry
//   through the RAM read port, the commit state and the output load before
//   rsp_tvalid rises. Flush and the unused mode go straight to the output load.
// Flow: one transaction at a time; req_tready returns in the same cycle that
//   rsp_tvalid rises, so lookup/insert throughput is set by the one-entry-per-cycle
//   RAM scan; the output load waits while a held response is not taken.
// Reset (synchronous): valid bits, stamp counter, FSM and output valid clear;
//   no RAM clearing pass, entries with a clear valid bit read as all zero.
`default_nettype none

module fully_assoc_tlb_fifo_unit #(
   parameter int unsigned TLB_ENTRIES = fatlb_pkg::TLB_ENTRIES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // [31:0] virtual_address, [63:32] physical_address
   input  wire logic [fatlb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] mode
   input  wire logic [fatlb_pkg::MODE_W-1:0]       req_tuser,
   // response channel
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [31:0] translated_address
   output      logic [fatlb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [0] hit
   output      logic                               rsp_tuser
);

   localparam int unsigned IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int unsigned STEP_W = $clog2(TLB_ENTRIES + 1);
   localparam int unsigned AW     = fatlb_pkg::ADDR_W;
   localparam int unsigned SW     = fatlb_pkg::STAMP_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;
   localparam logic [1:0] ST_RESP   = 2'd3;

   // control state
   logic [1:0]             state_ff,     state_in;
   logic [STEP_W-1:0]      step_ff,      step_in;
   logic                   rd_pend_ff,   rd_pend_in;
   logic [TLB_ENTRIES-1:0] vld_ff,       vld_in;
   logic [SW-1:0]          stamp_ff,     stamp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload / scan state
   logic [fatlb_pkg::MODE_W-1:0] mode_ff,  mode_in;
   logic [AW-1:0]          vaddr_ff,      vaddr_in;
   logic [AW-1:0]          paddr_ff,      paddr_in;
   logic [IDX_W-1:0]       rd_idx_ff,     rd_idx_in;
   logic                   hit_ff,        hit_in;
   logic [AW-1:0]          frame_ff,      frame_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff,   free_idx_in;
   logic [IDX_W-1:0]       victim_ff,     victim_in;
   logic [SW-1:0]          min_age_ff,    min_age_in;
   logic                   rsp_hit_ff,    rsp_hit_in;
   logic [AW-1:0]          rsp_addr_ff,   rsp_addr_in;

   // RAM port
   logic                          ram_wr_en;
   logic [IDX_W-1:0]              ram_wr_addr;
   fatlb_pkg::entry_type          ram_wr_data;
   logic                          ram_rd_en;
   logic [IDX_W-1:0]              ram_rd_addr;
   logic [fatlb_pkg::ENTRY_W-1:0] ram_rd_data;
   fatlb_pkg::entry_type          ent;

   fatlb_ram #(
      .WIDTH (fatlb_pkg::ENTRY_W),
      .DEPTH (TLB_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_hit_ff;

   // Entry returned by the RAM; a never-written or flushed slot reads as empty.
   assign ent = vld_ff[rd_idx_ff] ? fatlb_pkg::entry_type'(ram_rd_data)
                                  : fatlb_pkg::entry_type'('0);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      rd_pend_in    = 1'b0;
      vld_in        = vld_ff;
      stamp_in      = stamp_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      vaddr_in      = vaddr_ff;
      paddr_in      = paddr_ff;
      rd_idx_in     = rd_idx_ff;
      hit_in        = hit_ff;
      frame_in      = frame_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      victim_in     = victim_ff;
      min_age_in    = min_age_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_addr_in   = rsp_addr_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = free_found_ff ? free_idx_ff : victim_ff;
      ram_wr_data   = '{age: stamp_ff, frame: paddr_ff, tag: vaddr_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = step_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // compare stage: entry read in the previous cycle
      if (rd_pend_ff) begin
         if (mode_ff == fatlb_pkg::MODE_LOOKUP && !hit_ff && vaddr_ff != '0 &&
             ent.tag == vaddr_ff) begin
            hit_in   = 1'b1;
            frame_in = ent.frame;
         end
         if (ent.tag == '0 && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
         // strict less keeps the lowest index on equal stamps
         if (rd_idx_ff == '0 || ent.age < min_age_ff) begin
            victim_in  = rd_idx_ff;
            min_age_in = ent.age;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in       = req_tuser;
               vaddr_in      = req_tdata[AW-1:0];
               paddr_in      = req_tdata[2*AW-1:AW];
               hit_in        = 1'b0;
               frame_in      = '0;
               free_found_in = 1'b0;
               step_in       = '0;
               case (req_tuser)
                  fatlb_pkg::MODE_LOOKUP,
                  fatlb_pkg::MODE_INSERT: begin
                     state_in = ST_SCAN;
                  end
                  fatlb_pkg::MODE_FLUSH: begin
                     vld_in   = '0;
                     state_in = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (step_ff == STEP_W'(TLB_ENTRIES)) begin
               state_in = ST_COMMIT;
            end else begin
               ram_rd_en  = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = step_ff[IDX_W-1:0];
               step_in    = step_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            if (mode_ff == fatlb_pkg::MODE_INSERT) begin
               ram_wr_en           = 1'b1;
               vld_in[ram_wr_addr] = 1'b1;
               stamp_in            = stamp_ff + 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_addr_in  = frame_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         vld_ff       <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rd_pend_ff   <= rd_pend_in;
         vld_ff       <= vld_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      vaddr_ff      <= vaddr_in;
      paddr_ff      <= paddr_in;
      rd_idx_ff     <= rd_idx_in;
      hit_ff        <= hit_in;
      frame_ff      <= frame_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      victim_ff     <= victim_in;
      min_age_ff    <= min_age_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

endmodule

`default_nettype wire

FILE: rtl/fatlb_checker.sv
// Port-level checks for fully_assoc_tlb_fifo_unit, bound to the top level.
// Depends on fatlb_pkg.
`default_nettype none

module fatlb_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [fatlb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                              rsp_tuser
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one transaction in flight: accept closes the request side
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // a miss never carries an address
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero translated address");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind fully_assoc_tlb_fifo_unit fatlb_checker u_fatlb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
